@@ rtl/core/sfd_pkg.sv @@
package sfd_pkg;

  localparam int RING_DEPTH  = 131072;
  localparam int SAMPLE_BITS = 24;

  localparam int ADDR_W  = $clog2(RING_DEPTH);
  localparam int LEN_W   = ADDR_W + 1;
  localparam int WORD_W  = 2 * SAMPLE_BITS;
  localparam int DATA_W  = ((WORD_W + 7) / 8) * 8;

  // Delay time is unsigned Q17.16 samples.
  localparam int DELAY_W = 33;
  localparam int FRAC_W  = 16;
  localparam int INT_W   = DELAY_W - FRAC_W;

  localparam int MIX_W   = 17;
  localparam int FB_W    = 16;
  localparam int RLEN_W  = 18;

  // One-pole smoother: step = round(|d| * 16777 / 2^24).
  localparam int COEF_W       = 15;
  localparam int SMOOTH_SHIFT = 24;
  localparam logic [COEF_W-1:0] SMOOTH_COEF = 15'd16777;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DELAY_W;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_DRY_WET  = 2'd0;
  localparam cfg_idx_t REG_FEEDBACK = 2'd1;
  localparam cfg_idx_t REG_TARGET   = 2'd2;
  localparam cfg_idx_t REG_RING_LEN = 2'd3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } ring_req_t;

  typedef struct packed {
    logic load_x;
    logic load_a;
    logic interp;
    logic mix;
  } chan_ctrl_t;

endpackage

@@ rtl/core/sfd_ring.sv @@
module sfd_ring (
  input  logic                        clk_i,
  input  sfd_pkg::ring_req_t          req_i,
  output logic [sfd_pkg::WORD_W-1:0]  rdata_o
);

  logic [sfd_pkg::WORD_W-1:0] mem_q [sfd_pkg::RING_DEPTH];
  logic [sfd_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sfd_rem.sv @@
module sfd_rem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sfd_pkg::INT_W-1:0]   num_i,
  input  logic [sfd_pkg::LEN_W-1:0]   den_i,
  output logic                        done_o,
  output logic [sfd_pkg::ADDR_W-1:0]  rem_o
);

  localparam int CNT_W = $clog2(sfd_pkg::INT_W);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [sfd_pkg::INT_W-1:0]   num_q, num_d;
  logic [sfd_pkg::ADDR_W-1:0]  rem_q, rem_d;
  logic [sfd_pkg::LEN_W-1:0]   trial;

  // Restoring remainder, one dividend bit per cycle. The remainder stays
  // below the divisor, so it always fits the ring address width.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    trial  = {rem_q, num_q[sfd_pkg::INT_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = num_i;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[sfd_pkg::INT_W-2:0], 1'b0};
      if (trial >= den_i) begin
        rem_d = sfd_pkg::ADDR_W'(trial - den_i);
      end else begin
        rem_d = trial[sfd_pkg::ADDR_W-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(sfd_pkg::INT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/core/sfd_chan.sv @@
module sfd_chan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sfd_pkg::chan_ctrl_t         ctrl_i,
  input  sfd_pkg::sample_t            x_i,
  input  sfd_pkg::sample_t            rd_i,
  input  logic [sfd_pkg::FRAC_W-1:0]  frac_i,
  input  logic [sfd_pkg::FB_W-1:0]    fb_gain_i,
  input  logic [sfd_pkg::MIX_W-1:0]   mix_gain_i,
  output sfd_pkg::sample_t            wr_o,
  output sfd_pkg::sample_t            y_o
);

  localparam int S     = sfd_pkg::SAMPLE_BITS;
  localparam int F     = sfd_pkg::FRAC_W;
  localparam int SAT_W = S + 8;
  localparam int IP_W  = S + F + 2;
  localparam int MX_W  = S + F + 4;
  localparam int FB_AW = S + F + 2;
  localparam int HALF  = 1 << (F - 1);

  function automatic sfd_pkg::sample_t sat(input logic signed [SAT_W-1:0] v);
    sfd_pkg::sample_t r;
    if (&v[SAT_W-1:S-1] || ~|v[SAT_W-1:S-1]) begin
      r = v[S-1:0];
    end else if (v[SAT_W-1]) begin
      r = {1'b1, {(S-1){1'b0}}};
    end else begin
      r = {1'b0, {(S-1){1'b1}}};
    end
    return r;
  endfunction

  sfd_pkg::sample_t x_q, a_q, dl_q, y_q, echo_q;
  sfd_pkg::sample_t dl_d, echo_d, y_d;

  logic signed [S:0]        ip_diff, mx_diff, wr_sum;
  logic signed [IP_W-1:0]   ip_acc;
  logic signed [MX_W-1:0]   mx_acc, mx_shift;
  logic signed [FB_AW-1:0]  fb_acc;

  // Interpolation as a + (b - a) * f keeps one multiplier in the path.
  always_comb begin
    ip_diff = (S+1)'(rd_i) - (S+1)'(a_q);
    ip_acc  = (IP_W'(a_q) <<< F)
            + IP_W'(ip_diff) * IP_W'($signed({1'b0, frac_i}))
            + IP_W'(HALF);
    dl_d    = ip_acc[F+S-1:F];
  end

  // Mix as d + (x - d) * g; the feedback product runs beside it.
  always_comb begin
    mx_diff  = (S+1)'(x_q) - (S+1)'(dl_q);
    mx_acc   = (MX_W'(dl_q) <<< F)
             + MX_W'(mx_diff) * MX_W'($signed({1'b0, mix_gain_i}))
             + MX_W'(HALF);
    mx_shift = mx_acc >>> F;
    y_d      = sat($signed(mx_shift[SAT_W-1:0]));
    fb_acc   = FB_AW'(dl_q) * FB_AW'($signed({1'b0, fb_gain_i})) + FB_AW'(HALF);
    echo_d   = fb_acc[F+S-1:F];
  end

  always_comb begin
    wr_sum = (S+1)'(x_q) + (S+1)'(echo_q);
    wr_o   = sat(SAT_W'(wr_sum));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_q <= '0;
    end else if (ctrl_i.mix) begin
      echo_q <= echo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_x) begin
      x_q <= x_i;
    end
    if (ctrl_i.load_a) begin
      a_q <= rd_i;
    end
    if (ctrl_i.interp) begin
      dl_q <= dl_d;
    end
    if (ctrl_i.mix) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

@@ rtl/core/stereo_feedback_delay.sv @@
// Stereo feedback delay with a gliding, linearly interpolated read tap.
// Input words arrive on the s_axis channel, one stereo Q1.23 pair per word;
// the mixed pair leaves on m_axis. Registers are written through the cfg
// channel (index, data), which is always ready; write them only while the
// block is idle.
// Each word runs the states MAG, STEP, DIV, ADDR, RD0, RD1, INTERP, MIX and
// OUT before its result is placed on m_axis; no new word is taken before then.
// The delay modulo the ring length needs a 17-step remainder unit, and a
// single memory port does one ring write and two neighbor reads per word.
// Both channels share one ring memory, one entry holding the left and right
// samples. The memory is not cleared after reset: a fill level tracks how
// far the write head has ever advanced, and entries at or above it read as zero,
// so the block accepts words right after reset.
// A finished result waits in the output register while the next word is
// accepted and processed; if the receiver still stalls when that word is
// done, the block holds it and does not accept another word.
module stereo_feedback_delay (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [23:0] left_in, [47:24] right_in
  input  logic [sfd_pkg::DATA_W-1:0]        s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [23:0] left_out, [47:24] right_out
  output logic [sfd_pkg::DATA_W-1:0]        m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int S      = sfd_pkg::SAMPLE_BITS;
  localparam int AW     = sfd_pkg::ADDR_W;
  localparam int LW     = sfd_pkg::LEN_W;
  localparam int DW     = sfd_pkg::DELAY_W;
  localparam int CMP_W  = (LW > sfd_pkg::RLEN_W) ? LW : sfd_pkg::RLEN_W;
  localparam int T_W    = LW + 1;
  localparam int PROD_W = DW + sfd_pkg::COEF_W;
  localparam int STEP_W = PROD_W - sfd_pkg::SMOOTH_SHIFT;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_MAG    = 10'b00_0000_0010,
    ST_STEP   = 10'b00_0000_0100,
    ST_DIV    = 10'b00_0000_1000,
    ST_ADDR   = 10'b00_0001_0000,
    ST_RD0    = 10'b00_0010_0000,
    ST_RD1    = 10'b00_0100_0000,
    ST_INTERP = 10'b00_1000_0000,
    ST_MIX    = 10'b01_0000_0000,
    ST_OUT    = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [sfd_pkg::MIX_W-1:0]  dry_wet_q;
  logic [sfd_pkg::FB_W-1:0]   feedback_q;
  logic [DW-1:0]              target_q;
  logic [sfd_pkg::RLEN_W-1:0] ring_len_q;

  logic [AW-1:0]  wp_q, wp_d;
  logic [LW-1:0]  fill_q, fill_d;
  logic [DW-1:0]  sm_q, sm_d;
  logic           primed_q, primed_d;
  logic [DW-1:0]  mag_q, mag_d;
  logic           add_q, add_d;
  logic [AW-1:0]  i0_q, i0_d, i1_q, i1_d;
  logic           start_q, start_d;
  logic           out_valid_q, out_valid_d;
  logic [sfd_pkg::DATA_W-1:0] out_data_q, out_data_d;

  logic                        s_accept;
  logic [CMP_W-1:0]            len_full;
  logic [LW-1:0]               len;
  logic [sfd_pkg::MIX_W-1:0]   mix_gain;
  logic [LW-1:0]               wp_inc;
  logic [PROD_W-1:0]           step_prod;
  logic [DW-1:0]               step;
  logic [T_W-1:0]              rd_t;
  logic [LW-1:0]               i0_inc;
  logic [AW-1:0]               i0_w, i1_w;
  logic [sfd_pkg::FRAC_W-1:0]  read_frac;
  logic                        div_done;
  logic [AW-1:0]               div_rem;
  logic                        rd_ok;
  logic [sfd_pkg::WORD_W-1:0]  rdata;

  sfd_pkg::ring_req_t   ring_req;
  sfd_pkg::chan_ctrl_t  chan_ctrl;
  sfd_pkg::sample_t     rd_l, rd_r, wr_l, wr_r, y_l, y_r;

  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dry_wet_q  <= 17'd32768;
      feedback_q <= 16'd32768;
      target_q   <= 33'd1572864000;
      ring_len_q <= 18'd131072;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sfd_pkg::REG_DRY_WET:  dry_wet_q  <= cfg_data_i[sfd_pkg::MIX_W-1:0];
        sfd_pkg::REG_FEEDBACK: feedback_q <= cfg_data_i[sfd_pkg::FB_W-1:0];
        sfd_pkg::REG_TARGET:   target_q   <= cfg_data_i[DW-1:0];
        sfd_pkg::REG_RING_LEN: ring_len_q <= cfg_data_i[sfd_pkg::RLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (CMP_W'(ring_len_q) < CMP_W'(2)) begin
      len_full = CMP_W'(2);
    end else if (CMP_W'(ring_len_q) > CMP_W'(sfd_pkg::RING_DEPTH)) begin
      len_full = CMP_W'(sfd_pkg::RING_DEPTH);
    end else begin
      len_full = CMP_W'(ring_len_q);
    end
    len = LW'(len_full);
    mix_gain = (dry_wet_q > sfd_pkg::MIX_W'(1 << sfd_pkg::FRAC_W)) ?
               sfd_pkg::MIX_W'(1 << sfd_pkg::FRAC_W) : dry_wet_q;
  end

  assign wp_inc    = {1'b0, wp_q} + 1'b1;
  assign step_prod = PROD_W'(mag_q) * PROD_W'(sfd_pkg::SMOOTH_COEF)
                   + PROD_W'(1 << (sfd_pkg::SMOOTH_SHIFT - 1));
  assign step      = DW'(step_prod[PROD_W-1:sfd_pkg::SMOOTH_SHIFT]);

  // Read point is write head minus delay. A nonzero fraction moves the lower
  // neighbor back one entry and weights the upper one by 1 - fraction.
  assign read_frac = -sm_q[sfd_pkg::FRAC_W-1:0];

  always_comb begin
    rd_t = {2'b00, wp_q} - {2'b00, div_rem} - T_W'(|sm_q[sfd_pkg::FRAC_W-1:0]);
    if (rd_t[T_W-1]) begin
      rd_t = rd_t + {1'b0, len};
    end
    i0_w   = rd_t[AW-1:0];
    i0_inc = {1'b0, i0_w} + 1'b1;
    i1_w   = (i0_inc == len) ? '0 : i0_inc[AW-1:0];
  end

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    sm_d        = sm_q;
    primed_d    = primed_q;
    mag_d       = mag_q;
    add_d       = add_q;
    i0_d        = i0_q;
    i1_d        = i1_q;
    start_d     = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          if ({1'b0, wp_q} >= len) begin
            wp_d = '0;
          end
          if (!primed_q) begin
            sm_d     = target_q;
            primed_d = 1'b1;
          end
          state_d = ST_MAG;
        end
      end
      ST_MAG: begin
        if (sm_q >= target_q) begin
          mag_d = sm_q - target_q;
          add_d = 1'b0;
        end else begin
          mag_d = target_q - sm_q;
          add_d = 1'b1;
        end
        if (wp_inc > fill_q) begin
          fill_d = wp_inc;
        end
        state_d = ST_STEP;
      end
      ST_STEP: begin
        sm_d    = add_q ? (sm_q + step) : (sm_q - step);
        start_d = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        i0_d    = i0_w;
        i1_d    = i1_w;
        state_d = ST_RD0;
      end
      ST_RD0:    state_d = ST_RD1;
      ST_RD1:    state_d = ST_INTERP;
      ST_INTERP: state_d = ST_MIX;
      ST_MIX: begin
        wp_d    = (wp_inc >= len) ? '0 : wp_inc[AW-1:0];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = sfd_pkg::DATA_W'({y_r, y_l});
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      sm_q        <= '0;
      primed_q    <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      sm_q        <= sm_d;
      primed_q    <= primed_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    add_q      <= add_d;
    i0_q       <= i0_d;
    i1_q       <= i1_d;
    out_data_q <= out_data_d;
  end

  sfd_rem u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .num_i   (sm_q[DW-1:sfd_pkg::FRAC_W]),
    .den_i   (len),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  // The ring write lands before both reads, so a zero delay reads back the
  // word written for this item.
  always_comb begin
    ring_req.we    = (state_q == ST_MAG);
    ring_req.re    = (state_q == ST_RD0) || (state_q == ST_RD1);
    ring_req.wdata = {wr_r, wr_l};
    if (state_q == ST_MAG) begin
      ring_req.addr = wp_q;
    end else if (state_q == ST_RD0) begin
      ring_req.addr = i0_q;
    end else begin
      ring_req.addr = i1_q;
    end
  end

  sfd_ring u_ring (
    .clk_i   (clk_i),
    .req_i   (ring_req),
    .rdata_o (rdata)
  );

  // Entries at or above the fill level were never written and read as zero.
  always_comb begin
    if (state_q == ST_RD1) begin
      rd_ok = ({1'b0, i0_q} < fill_q);
    end else begin
      rd_ok = ({1'b0, i1_q} < fill_q);
    end
    rd_l = rd_ok ? rdata[S-1:0] : '0;
    rd_r = rd_ok ? rdata[2*S-1:S] : '0;
    chan_ctrl.load_x = s_accept;
    chan_ctrl.load_a = (state_q == ST_RD1);
    chan_ctrl.interp = (state_q == ST_INTERP);
    chan_ctrl.mix    = (state_q == ST_MIX);
  end

  sfd_chan u_chan_l (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (chan_ctrl),
    .x_i        (s_axis_tdata[S-1:0]),
    .rd_i       (rd_l),
    .frac_i     (read_frac),
    .fb_gain_i  (feedback_q),
    .mix_gain_i (mix_gain),
    .wr_o       (wr_l),
    .y_o        (y_l)
  );

  sfd_chan u_chan_r (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (chan_ctrl),
    .x_i        (s_axis_tdata[2*S-1:S]),
    .rd_i       (rd_r),
    .frac_i     (read_frac),
    .fb_gain_i  (feedback_q),
    .mix_gain_i (mix_gain),
    .wr_o       (wr_r),
    .y_o        (y_r)
  );

endmodule

@@ rtl/core/sfd_checker.sv @@
module sfd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [sfd_pkg::DATA_W-1:0]        m_axis_tdata
);

  // A stalled result word must hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed or dropped while stalled");

  // Only one word is in work at a time; the input is not ready right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready
      ##1 !s_axis_tready)
    else $error("input accepted again too soon");

  // The block goes back to accepting words only when it hands over a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready) |-> m_axis_tvalid)
    else $error("block became ready without presenting a result");

endmodule

bind stereo_feedback_delay sfd_checker u_sfd_checker (.*);

@@ test/stereo_feedback_delay_tb.sv @@
module stereo_feedback_delay_tb;

  localparam int WATCHDOG         = 1000;
  localparam int SETTLE           = 60;
  localparam int PHASES           = 8;
  localparam int FRAMES_PER_PHASE = 180;

  localparam sfd_pkg::sample_t S_MAX = 24'h7FFFFF;
  localparam sfd_pkg::sample_t S_MIN = 24'h800000;
  localparam sfd_pkg::sample_t ZERO  = 24'sd0;

  typedef struct packed {
    sfd_pkg::sample_t right;
    sfd_pkg::sample_t left;
  } stereo_t;

  typedef struct packed {
    bit      known;
    stereo_t frame;
  } typed_frame_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    sfd_pkg::cfg_idx_t  idx;
    logic [32:0]        val;
    sfd_pkg::sample_t   in_l;
    sfd_pkg::sample_t   in_r;
    bit                 known;
    sfd_pkg::sample_t   out_l;
    sfd_pkg::sample_t   out_r;
  } plan_row_t;

  // Rows with known set carry an output that follows directly from the inputs.
  localparam plan_row_t PLAN [34] = '{
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, ZERO, ZERO, 1'b1, ZERO, ZERO},
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, S_MAX, S_MIN, 1'b1, 24'sd4194304, -24'sd4194304},
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, S_MIN, S_MAX, 1'b1, -24'sd4194304, 24'sd4194304},
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, 24'sd1, -24'sd1, 1'b1, 24'sd1, ZERO},
    '{ROW_CFG, sfd_pkg::REG_DRY_WET, 33'd65536, ZERO, ZERO, 1'b0, ZERO, ZERO},
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, S_MAX, S_MIN, 1'b1, S_MAX, S_MIN},
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, -24'sd1, 24'sd1, 1'b1, -24'sd1, 24'sd1},
    '{ROW_CFG, sfd_pkg::REG_DRY_WET, 33'd131071, ZERO, ZERO, 1'b0, ZERO, ZERO},
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, 24'sd123456, -24'sd654321,
      1'b1, 24'sd123456, -24'sd654321},
    // Two entries divide the reset delay exactly, so the read tap sits on the write head.
    '{ROW_CFG, sfd_pkg::REG_FEEDBACK, 33'd0, ZERO, ZERO, 1'b0, ZERO, ZERO},
    '{ROW_CFG, sfd_pkg::REG_DRY_WET, 33'd0, ZERO, ZERO, 1'b0, ZERO, ZERO},
    '{ROW_CFG, sfd_pkg::REG_RING_LEN, 33'd2, ZERO, ZERO, 1'b0, ZERO, ZERO},
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, S_MIN, S_MAX, 1'b1, S_MIN, S_MAX},
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, 24'sd5, -24'sd7, 1'b1, 24'sd5, -24'sd7},
    '{ROW_CFG, sfd_pkg::REG_FEEDBACK, 33'd64225, ZERO, ZERO, 1'b0, ZERO, ZERO},
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, S_MAX, S_MIN, 1'b0, ZERO, ZERO},
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, S_MAX, S_MIN, 1'b0, ZERO, ZERO},
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, 24'sd4000000, -24'sd4000000, 1'b0, ZERO, ZERO},
    '{ROW_CFG, sfd_pkg::REG_FEEDBACK, 33'd65535, ZERO, ZERO, 1'b0, ZERO, ZERO},
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, S_MAX, S_MIN, 1'b0, ZERO, ZERO},
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, ZERO, ZERO, 1'b0, ZERO, ZERO},
    '{ROW_CFG, sfd_pkg::REG_RING_LEN, 33'd0, ZERO, ZERO, 1'b0, ZERO, ZERO},
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, 24'sd1234567, -24'sd7654321, 1'b0, ZERO, ZERO},
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, -24'sd1, -24'sd1, 1'b0, ZERO, ZERO},
    '{ROW_CFG, sfd_pkg::REG_TARGET, 33'h1_FFFF_FFFF, ZERO, ZERO, 1'b0, ZERO, ZERO},
    '{ROW_CFG, sfd_pkg::REG_RING_LEN, 33'd3, ZERO, ZERO, 1'b0, ZERO, ZERO},
    '{ROW_CFG, sfd_pkg::REG_DRY_WET, 33'd1, ZERO, ZERO, 1'b0, ZERO, ZERO},
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, S_MAX, 24'sd3, 1'b0, ZERO, ZERO},
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, -24'sd2, S_MIN, 1'b0, ZERO, ZERO},
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, 24'sd8388606, -24'sd8388607, 1'b0, ZERO, ZERO},
    '{ROW_CFG, sfd_pkg::REG_RING_LEN, 33'd262143, ZERO, ZERO, 1'b0, ZERO, ZERO},
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, 24'sd111111, -24'sd222222, 1'b0, ZERO, ZERO},
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, S_MIN, S_MIN, 1'b0, ZERO, ZERO},
    '{ROW_ITEM, sfd_pkg::REG_DRY_WET, 33'd0, S_MAX, S_MAX, 1'b0, ZERO, ZERO}
  };

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [sfd_pkg::DATA_W-1:0]     s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [sfd_pkg::DATA_W-1:0]     m_axis_tdata;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  sfd_pkg::cfg_idx_t              cfg_index_i = sfd_pkg::REG_DRY_WET;
  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  stereo_feedback_delay dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: both rings start cleared, the delay glide starts unprimed.
  int              ring_l [sfd_pkg::RING_DEPTH];
  int              ring_r [sfd_pkg::RING_DEPTH];
  int unsigned     head;
  longint unsigned glide;
  bit              primed;
  longint          echo_l, echo_r;
  longint          mix_gain = 32768;
  longint          fb_gain = 32768;
  longint unsigned target_reg = 1572864000;
  longint unsigned ring_len = 131072;

  stereo_t      expected_frames [$];
  typed_frame_t typed_frames [$];
  int           mismatches;
  bit           idle_en = 1'b1;
  int           stall_left;
  int           quiet_cycles;

  function automatic longint clamp_q23(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // Rounds half up on a 16-bit fraction; the arithmetic shift floors negatives.
  function automatic longint round_q16(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic void run_echo_frame(input stereo_t x, output stereo_t y);
    longint unsigned len, span, dmod, mag, stp;
    longint          pos, fr, dl, dr, g;
    int unsigned     i0, i1;
    len = ring_len;
    if (len < 2) len = 2;
    if (len > sfd_pkg::RING_DEPTH) len = 64'(sfd_pkg::RING_DEPTH);
    if (head >= len) head = 0;
    if (!primed) begin
      glide  = target_reg;
      primed = 1'b1;
    end
    if (glide >= target_reg) begin
      mag   = glide - target_reg;
      stp   = (mag * 64'd16777 + 64'd8388608) >> 24;
      glide = glide - stp;
    end else begin
      mag   = target_reg - glide;
      stp   = (mag * 64'd16777 + 64'd8388608) >> 24;
      glide = glide + stp;
    end
    glide &= 64'h1_FFFF_FFFF;

    ring_l[head] = int'(clamp_q23(longint'(x.left) + echo_l));
    ring_r[head] = int'(clamp_q23(longint'(x.right) + echo_r));

    // The delay wraps around the ring as many times as it needs to.
    span = len << 16;
    dmod = glide % span;
    pos  = longint'(head) * 65536 - longint'(dmod);
    if (pos < 0) pos += longint'(span);
    i0 = 32'(pos / 65536);
    fr = pos % 65536;
    i1 = i0 + 1;
    if (i1 >= len) i1 = 0;
    if (i0 >= len) i0 = 0;

    dl = round_q16(longint'(ring_l[i0]) * (65536 - fr) + longint'(ring_l[i1]) * fr);
    dr = round_q16(longint'(ring_r[i0]) * (65536 - fr) + longint'(ring_r[i1]) * fr);
    echo_l = round_q16(dl * fb_gain);
    echo_r = round_q16(dr * fb_gain);

    g = (mix_gain > 65536) ? 65536 : mix_gain;
    y.left  = sfd_pkg::sample_t'(clamp_q23(round_q16(longint'(x.left) * g
                                                     + dl * (65536 - g))));
    y.right = sfd_pkg::sample_t'(clamp_q23(round_q16(longint'(x.right) * g
                                                     + dr * (65536 - g))));

    head++;
    if (head >= len) head = 0;
  endfunction

  function automatic sfd_pkg::sample_t rand_sample();
    case ($urandom_range(0, 7))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return sfd_pkg::sample_t'($urandom_range(0, 2000)) - 24'sd1000;
      default: return sfd_pkg::sample_t'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    stereo_t      got, want;
    typed_frame_t typed;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          sfd_pkg::REG_DRY_WET:  mix_gain   = longint'(cfg_data_i[16:0]);
          sfd_pkg::REG_FEEDBACK: fb_gain    = longint'(cfg_data_i[15:0]);
          sfd_pkg::REG_TARGET:   target_reg = 64'(cfg_data_i);
          sfd_pkg::REG_RING_LEN: ring_len   = 64'(cfg_data_i[17:0]);
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[2*sfd_pkg::SAMPLE_BITS-1:0];
        if (expected_frames.size() == 0) begin
          $error("m_axis word with nothing pending: left_out %0d, right_out %0d",
                 got.left, got.right);
          mismatches++;
        end else begin
          want = expected_frames.pop_front();
          if (got.left !== want.left) begin
            $error("left_out: expected %0d, got %0d", want.left, got.left);
            mismatches++;
          end
          if (got.right !== want.right) begin
            $error("right_out: expected %0d, got %0d", want.right, got.right);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        typed = typed_frames.pop_front();
        run_echo_frame(s_axis_tdata[2*sfd_pkg::SAMPLE_BITS-1:0], want);
        expected_frames.push_back(typed.known ? typed.frame : want);
      end
    end
  end

  // Receiver stalls come in bursts of random length.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input sfd_pkg::cfg_idx_t idx, input logic [32:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Valid stays high after a word is taken, so back-to-back words keep it up unless idle_en inserts a random gap.
  task automatic send_pair(input stereo_t pair);
    cfg_valid_i <= 1'b0;
    if (idle_en && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sfd_pkg::DATA_W'(pair);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_frames.size() != 0);
  endtask

  initial begin
    sfd_pkg::cfg_idx_t idx;
    logic [32:0]       v;
    stereo_t           pair;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (PLAN[k]) begin
      if (PLAN[k].kind == ROW_CFG) begin
        if (k > 0 && PLAN[k-1].kind == ROW_ITEM) wait_drained();
        write_reg(PLAN[k].idx, PLAN[k].val);
      end else begin
        typed_frames.push_back('{PLAN[k].known,
                                 '{right: PLAN[k].out_r, left: PLAN[k].out_l}});
        send_pair('{right: PLAN[k].in_r, left: PLAN[k].in_l});
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      idle_en = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < 4; k++) begin
        idx = sfd_pkg::cfg_idx_t'(k);
        if ($urandom_range(0, 1) == 0) continue;
        case (idx)
          sfd_pkg::REG_DRY_WET: begin
            case ($urandom_range(0, 4))
              0:       v = 33'd0;
              1:       v = 33'd65536;
              2:       v = 33'($urandom_range(65537, 131071));
              default: v = 33'($urandom_range(0, 65536));
            endcase
          end
          sfd_pkg::REG_FEEDBACK: begin
            case ($urandom_range(0, 5))
              0:       v = 33'd0;
              1:       v = 33'd64225;
              2:       v = 33'($urandom_range(64226, 65535));
              default: v = 33'($urandom_range(0, 64225));
            endcase
          end
          sfd_pkg::REG_TARGET: begin
            // A small step from the current target lets the glide settle and stop.
            case ($urandom_range(0, 7))
              0:       v = 33'd0;
              1:       v = 33'h1_FFFF_FFFF;
              2:       v = 33'({$urandom, $urandom});
              3:       v = 33'(target_reg + $urandom_range(0, 3000) - 1500);
              default: v = 33'(($urandom_range(0, 96) << 16) | $urandom_range(0, 65535));
            endcase
          end
          default: begin
            case ($urandom_range(0, 9))
              0:       v = 33'($urandom_range(0, 1));
              1:       v = 33'($urandom_range(65, 4096));
              2:       v = $urandom_range(0, 1) ? 33'd131072
                                                : 33'($urandom_range(131073, 262143));
              default: v = 33'($urandom_range(2, 64));
            endcase
          end
        endcase
        write_reg(idx, v);
      end

      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        if (ph == 3 && n == FRAMES_PER_PHASE / 2) wait_drained();
        pair.left  = rand_sample();
        pair.right = rand_sample();
        typed_frames.push_back('{1'b0, '0});
        send_pair(pair);
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
